### hw/rtl/bqf_pkg.sv
// Package for the biquad IIR filter: widths, register indexes and the
// command types between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bqf_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEF_WIDTH      = 18;
    localparam int STATE_WIDTH     = 40;
    localparam int FRAC_BITS       = 16;
    localparam int OUT_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    // A 40-bit state operand is split into a signed upper half and an
    // unsigned lower half so that each partial product stays narrow.
    localparam int LO_WIDTH      = STATE_WIDTH / 2;
    localparam int HI_WIDTH      = STATE_WIDTH - LO_WIDTH;
    localparam int PROD_LO_WIDTH = COEF_WIDTH + LO_WIDTH + 1;
    localparam int PROD_HI_WIDTH = COEF_WIDTH + HI_WIDTH;

    // Three products of 58 bits each sum into 60 bits without overflow.
    localparam int ACC_WIDTH = COEF_WIDTH + STATE_WIDTH + 2;

    // Rounded feedback sum, and the width in which x << 16 minus it is formed.
    localparam int FB_WIDTH   = ACC_WIDTH - FRAC_BITS;
    localparam int WIDE_WIDTH =
        ((SAMPLE_WIDTH + FRAC_BITS > FB_WIDTH) ? SAMPLE_WIDTH + FRAC_BITS : FB_WIDTH) + 1;

    // Output before extension to 32 bits; it is narrower than the output.
    localparam int Y_WIDTH = ACC_WIDTH - 2 * FRAC_BITS;

    localparam logic [ACC_WIDTH-1:0] FB_ROUND_HALF  = ACC_WIDTH'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_WIDTH-1:0] OUT_ROUND_HALF = ACC_WIDTH'(1) << (2 * FRAC_BITS - 1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FB_COEF_1 = 3'd0,
        CFG_FB_COEF_2 = 3'd1,
        CFG_FF_COEF_0 = 3'd2,
        CFG_FF_COEF_1 = 3'd3,
        CFG_FF_COEF_2 = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_A1_W1,
        MUL_A2_W2,
        MUL_B0_W,
        MUL_B1_W1,
        MUL_B2_W2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load_x;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     w_en;
        logic     out_en;
    } bqf_cmd_t;

endpackage

### hw/rtl/bqf_sample_if.sv
// Input sample channel: valid/ready handshake with a signed sample.
// Depends on bqf_pkg.
`timescale 1ns / 1ps

interface bqf_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### hw/rtl/bqf_filtered_if.sv
// Result channel: valid/ready handshake with the filtered output.
// Depends on bqf_pkg.
`timescale 1ns / 1ps

interface bqf_filtered_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bqf_pkg::OUT_WIDTH-1:0]  filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

### hw/rtl/bqf_ctrl.sv
// Sequencer for the biquad filter: steps the shared multiplier and
// accumulator through the five products. Depends on bqf_pkg.
`timescale 1ns / 1ps

module bqf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bqf_pkg::bqf_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MA1  = 8'b0000_0010,
        ST_MA2  = 8'b0000_0100,
        ST_FBS  = 8'b0000_1000,
        ST_WUP  = 8'b0001_0000,
        ST_MB0  = 8'b0010_0000,
        ST_ACCF = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.load_x     = 1'b0;
        cmd.mul_sel    = bqf_pkg::MUL_A1_W1;
        cmd.acc_op     = bqf_pkg::ACC_HOLD;
        cmd.w_en       = 1'b0;
        cmd.out_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_x = 1'b1;
                    state_next = ST_MA1;
                end
            end
            ST_MA1:
            begin
                cmd.mul_sel = bqf_pkg::MUL_A1_W1;
                state_next  = ST_MA2;
            end
            ST_MA2:
            begin
                cmd.mul_sel = bqf_pkg::MUL_A2_W2;
                cmd.acc_op  = bqf_pkg::ACC_LOAD;
                state_next  = ST_FBS;
            end
            ST_FBS:
            begin
                cmd.mul_sel = bqf_pkg::MUL_B1_W1;
                cmd.acc_op  = bqf_pkg::ACC_ADD;
                state_next  = ST_WUP;
            end
            ST_WUP:
            begin
                // The feedback sum is complete: form w while b1*w1 loads.
                cmd.w_en    = 1'b1;
                cmd.mul_sel = bqf_pkg::MUL_B2_W2;
                cmd.acc_op  = bqf_pkg::ACC_LOAD;
                state_next  = ST_MB0;
            end
            ST_MB0:
            begin
                cmd.mul_sel = bqf_pkg::MUL_B0_W;
                cmd.acc_op  = bqf_pkg::ACC_ADD;
                state_next  = ST_ACCF;
            end
            ST_ACCF:
            begin
                cmd.acc_op = bqf_pkg::ACC_ADD;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_en     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/bqf_datapath.sv
// Datapath of the biquad filter: coefficient registers, history, one
// shared split multiplier, the accumulator and the output register. Depends on bqf_pkg.
`timescale 1ns / 1ps

module bqf_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [bqf_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [bqf_pkg::COEF_WIDTH-1:0]           cfg_data,
    input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  sample,
    input  bqf_pkg::bqf_cmd_t                        cmd,
    output logic signed [bqf_pkg::OUT_WIDTH-1:0]     filtered
);

    logic signed [bqf_pkg::COEF_WIDTH-1:0]    fb_coef_1_reg, fb_coef_2_reg;
    logic signed [bqf_pkg::COEF_WIDTH-1:0]    ff_coef_0_reg, ff_coef_1_reg, ff_coef_2_reg;
    logic signed [bqf_pkg::STATE_WIDTH-1:0]   w1_reg, w2_reg, w_reg, w_next;
    logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  x_reg;
    logic signed [bqf_pkg::PROD_LO_WIDTH-1:0] prod_lo_reg, prod_lo_next;
    logic signed [bqf_pkg::PROD_HI_WIDTH-1:0] prod_hi_reg, prod_hi_next;
    logic signed [bqf_pkg::ACC_WIDTH-1:0]     acc_reg, acc_next, prod_sum;
    logic signed [bqf_pkg::OUT_WIDTH-1:0]     filtered_reg, filtered_next;

    logic signed [bqf_pkg::COEF_WIDTH-1:0]    mul_coef;
    logic signed [bqf_pkg::STATE_WIDTH-1:0]   mul_state;
    logic [bqf_pkg::ACC_WIDTH-1:0]            fb_biased, y_biased;
    logic signed [bqf_pkg::FB_WIDTH-1:0]      fb_round;
    logic signed [bqf_pkg::WIDE_WIDTH-1:0]    w_wide;
    logic signed [bqf_pkg::Y_WIDTH-1:0]       y_round;
    logic                                     w_in_range;

    // Coefficient writes; indexes beyond the five registers are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_coef_1_reg <= '0;
            fb_coef_2_reg <= '0;
            ff_coef_0_reg <= '0;
            ff_coef_1_reg <= '0;
            ff_coef_2_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (bqf_pkg::cfg_index_t'(cfg_index))
                bqf_pkg::CFG_FB_COEF_1: fb_coef_1_reg <= cfg_data;
                bqf_pkg::CFG_FB_COEF_2: fb_coef_2_reg <= cfg_data;
                bqf_pkg::CFG_FF_COEF_0: ff_coef_0_reg <= cfg_data;
                bqf_pkg::CFG_FF_COEF_1: ff_coef_1_reg <= cfg_data;
                bqf_pkg::CFG_FF_COEF_2: ff_coef_2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection and the two partial products.
    always_comb
    begin
        unique case (cmd.mul_sel)
            bqf_pkg::MUL_A1_W1:
            begin
                mul_coef  = fb_coef_1_reg;
                mul_state = w1_reg;
            end
            bqf_pkg::MUL_A2_W2:
            begin
                mul_coef  = fb_coef_2_reg;
                mul_state = w2_reg;
            end
            bqf_pkg::MUL_B0_W:
            begin
                mul_coef  = ff_coef_0_reg;
                mul_state = w_reg;
            end
            bqf_pkg::MUL_B1_W1:
            begin
                mul_coef  = ff_coef_1_reg;
                mul_state = w1_reg;
            end
            bqf_pkg::MUL_B2_W2:
            begin
                mul_coef  = ff_coef_2_reg;
                mul_state = w2_reg;
            end
            default:
            begin
                mul_coef  = fb_coef_1_reg;
                mul_state = w1_reg;
            end
        endcase
    end

    assign prod_lo_next = mul_coef
                        * $signed({1'b0, mul_state[bqf_pkg::LO_WIDTH-1:0]});
    assign prod_hi_next = mul_coef
                        * $signed(mul_state[bqf_pkg::STATE_WIDTH-1:bqf_pkg::LO_WIDTH]);

    // Recombine the registered partials into the full product.
    assign prod_sum = (bqf_pkg::ACC_WIDTH'(prod_hi_reg) <<< bqf_pkg::LO_WIDTH)
                    + bqf_pkg::ACC_WIDTH'(prod_lo_reg);

    always_comb
    begin
        unique case (cmd.acc_op)
            bqf_pkg::ACC_HOLD: acc_next = acc_reg;
            bqf_pkg::ACC_LOAD: acc_next = prod_sum;
            bqf_pkg::ACC_ADD:  acc_next = acc_reg + prod_sum;
            default:           acc_next = acc_reg;
        endcase
    end

    // Rounding half away from zero: add half, less one when negative, then
    // take the upper bits (an arithmetic shift).
    assign fb_biased = acc_reg + bqf_pkg::FB_ROUND_HALF
                     - bqf_pkg::ACC_WIDTH'(acc_reg[bqf_pkg::ACC_WIDTH-1]);
    assign fb_round  = $signed(fb_biased[bqf_pkg::ACC_WIDTH-1:bqf_pkg::FRAC_BITS]);

    assign w_wide = (bqf_pkg::WIDE_WIDTH'(x_reg) <<< bqf_pkg::FRAC_BITS)
                  - bqf_pkg::WIDE_WIDTH'(fb_round);

    // w fits when all bits from the state sign upward agree.
    assign w_in_range = (&w_wide[bqf_pkg::WIDE_WIDTH-1:bqf_pkg::STATE_WIDTH-1])
                      | ~(|w_wide[bqf_pkg::WIDE_WIDTH-1:bqf_pkg::STATE_WIDTH-1]);

    always_comb
    begin
        if (w_in_range)
        begin
            w_next = w_wide[bqf_pkg::STATE_WIDTH-1:0];
        end
        else if (w_wide[bqf_pkg::WIDE_WIDTH-1])
        begin
            w_next = {1'b1, {(bqf_pkg::STATE_WIDTH-1){1'b0}}};
        end
        else
        begin
            w_next = {1'b0, {(bqf_pkg::STATE_WIDTH-1){1'b1}}};
        end
    end

    // The rounded sum of three products always lies inside 32 bits, so the
    // output saturation reduces to sign extension.
    assign y_biased = acc_reg + bqf_pkg::OUT_ROUND_HALF
                    - bqf_pkg::ACC_WIDTH'(acc_reg[bqf_pkg::ACC_WIDTH-1]);
    assign y_round  = $signed(y_biased[bqf_pkg::ACC_WIDTH-1:2*bqf_pkg::FRAC_BITS]);
    assign filtered_next = bqf_pkg::OUT_WIDTH'(y_round);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg <= '0;
            w2_reg <= '0;
        end
        else if (cmd.out_en)
        begin
            w2_reg <= w1_reg;
            w1_reg <= w_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        acc_reg     <= acc_next;
        if (cmd.load_x)
        begin
            x_reg <= sample;
        end
        if (cmd.w_en)
        begin
            w_reg <= w_next;
        end
        if (cmd.out_en)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign filtered = filtered_reg;

endmodule

### hw/rtl/biquad_iir_filter.sv
// Top level of the biquad IIR filter (direct form II, Q2.16 coefficients,
// Q24.16 state). Depends on bqf_pkg, the channel interfaces, bqf_ctrl and bqf_datapath.
//
//   Channel       Direction  Payload                    Transfer when
//   sample_ch     in         sample   (16 bit signed)   valid && ready
//   filtered_ch   out        filtered (32 bit signed)   valid && ready
//   cfg port      in         cfg_index, cfg_data        cfg_we high
//
// A sample transfers in ST_IDLE; ST_MA1 through ST_ACCF then step the single
// shared multiplier and the accumulator through the five coefficient products,
// and ST_OUT rounds the result into the output register and shifts the history.
// The next sample is accepted only after ST_OUT, back in ST_IDLE.
// The output register lets a finished result wait while the next sample is
// accepted; a second result stalls only until the first has been taken.
// Reset (rst_n, asynchronous, active low) clears the coefficients, the
// history and all handshake state; there is no clearing pass.
`timescale 1ns / 1ps

module biquad_iir_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bqf_sample_if.sink                           sample_ch,
    bqf_filtered_if.source                       filtered_ch,
    input  logic                                 cfg_we,
    input  logic [bqf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bqf_pkg::COEF_WIDTH-1:0]       cfg_data
);

    // Command bundle from the sequencer to the datapath.
    bqf_pkg::bqf_cmd_t cmd;

    // The sequencer owns both handshakes; the datapath only follows commands.
    bqf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (filtered_ch.valid),
        .out_ready (filtered_ch.ready),
        .cmd       (cmd)
    );

    // Coefficients, history, multiplier, accumulator and result register.
    bqf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch.sample),
        .cmd       (cmd),
        .filtered  (filtered_ch.filtered)
    );

endmodule
